// File: rtl/yrst_pkg.sv
// Shared types and codes for the year-sorted record table.
// Used by yrst_cell and year_sorted_record_table; depends on nothing.
package yrst_pkg;

    localparam int CAPACITY_DEF = 10;

    localparam int YEAR_W    = 12;
    localparam int LETTERS_W = 24;
    localparam int DIGITS_W  = 32;

    // Request codes.
    localparam logic [1:0] REQ_INSERT   = 2'd0;
    localparam logic [1:0] REQ_LIST_ALL = 2'd1;
    localparam logic [1:0] REQ_LIST_YR  = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_RECORD   = 2'd0;
    localparam logic [1:0] ST_INSERTED = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NONE     = 2'd3;

    typedef struct packed {
        logic [YEAR_W-1:0]    year;
        logic [LETTERS_W-1:0] letters;
        logic [DIGITS_W-1:0]  digits;
    } rec_t;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_INSERT,
        CMD_ROTATE
    } cell_cmd_t;

    // Broadcast from the sequencer to every cell.
    typedef struct packed {
        cell_cmd_t cmd;
        logic      list_all;
        rec_t      new_rec;
    } cell_ctrl_t;

endpackage

// File: rtl/yrst_cell.sv
// One storage cell of the record chain: holds a single record.
// Depends on yrst_pkg for the record and control types.
module yrst_cell
(
    input  logic               clk,
    input  yrst_pkg::cell_ctrl_t ctrl,
    input  logic               occ,
    input  logic               tail,
    input  yrst_pkg::rec_t     left_rec,
    input  logic               left_gt,
    input  yrst_pkg::rec_t     right_rec,
    output yrst_pkg::rec_t     rec,
    output logic               gt,
    output logic               match
);

    yrst_pkg::rec_t rec_reg;
    yrst_pkg::rec_t rec_next;

    assign rec   = rec_reg;
    assign gt    = occ && (rec_reg.year > ctrl.new_rec.year);
    assign match = occ && (ctrl.list_all || (rec_reg.year == ctrl.new_rec.year));

    // On an insert the records above the new year move one place up; the
    // first cell that is greater, or the first free cell, takes the new record.
    always_comb
    begin
        rec_next = rec_reg;
        case (ctrl.cmd)
            yrst_pkg::CMD_INSERT:
            begin
                if (left_gt)
                begin
                    rec_next = left_rec;
                end
                else if (gt || tail)
                begin
                    rec_next = ctrl.new_rec;
                end
            end
            yrst_pkg::CMD_ROTATE:
            begin
                rec_next = right_rec;
            end
            default:
            begin
                rec_next = rec_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

endmodule

// File: rtl/year_sorted_record_table.sv
// Top level of the year-sorted record table: sequencer, output register
// and the chain of yrst_cell storage cells. Depends on yrst_pkg.
//
// Usage. Requests arrive as beats on the input channel (in_valid/in_stall)
// carrying req_type, year and the plate fields; results leave as beats on
// the output channel (out_valid/out_stall). An insert yields one beat
// (inserted or table full). A listing yields one beat per stored record
// that qualifies, in ascending year order with equal years in arrival
// order, or a single none-found beat; the final beat has last set.
// Request type 3 is dropped without a result.
// Flow. A listing rotates the whole chain once through cell 0, one cell per
// cycle unless a stalled beat holds it, so that the table ends where it began;
// a listing that finds nothing does not rotate.
// One request is taken at a time: in_stall stays high until an insert or
// none-found beat reaches the output register, or until a listing's
// rotation ends; the next request may enter while that beat still waits.
// Stalls. While out_stall holds a beat, the rotation pauses on any record
// that still has to be emitted, so no beat is lost or repeated.
// Reset. rst_n clears the record count, state and out_valid, never the records.
module year_sorted_record_table
#(
    parameter int CAPACITY = yrst_pkg::CAPACITY_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     req_type,
    input  logic [yrst_pkg::YEAR_W-1:0]    year,
    input  logic [yrst_pkg::LETTERS_W-1:0] plate_letters,
    input  logic [yrst_pkg::DIGITS_W-1:0]  plate_digits,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [1:0]                     status,
    output logic [yrst_pkg::YEAR_W-1:0]    rec_year,
    output logic [yrst_pkg::LETTERS_W-1:0] rec_letters,
    output logic [yrst_pkg::DIGITS_W-1:0]  rec_digits,
    output logic                           last
);

    localparam int FILL_W = $clog2(CAPACITY + 1);
    localparam int STEP_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INSERT,
        S_LSTART,
        S_LIST
    } state_t;

    state_t                state_reg, state_next;
    logic [FILL_W-1:0]     fill_reg, fill_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [CAPACITY-1:0]   mvec_reg, mvec_next;
    logic                  list_all_reg, list_all_next;
    yrst_pkg::rec_t        req_reg, req_next;

    logic                  out_valid_reg, out_valid_next;
    logic [1:0]            status_reg, status_next;
    yrst_pkg::rec_t        out_rec_reg, out_rec_next;
    logic                  last_reg, last_next;

    yrst_pkg::cell_ctrl_t  ctrl;
    yrst_pkg::rec_t        cell_rec [CAPACITY];
    logic [CAPACITY-1:0]   cell_gt;
    logic [CAPACITY-1:0]   cell_match;
    logic                  out_free;
    logic                  table_full;

    assign out_free   = !out_valid_reg || !out_stall;
    assign table_full = (fill_reg == FILL_W'(CAPACITY));
    assign in_stall   = (state_reg != S_IDLE);

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign rec_year    = out_rec_reg.year;
    assign rec_letters = out_rec_reg.letters;
    assign rec_digits  = out_rec_reg.digits;
    assign last        = last_reg;

    // The chain: each cell sees its lower neighbour for inserts and its upper
    // neighbour for rotation; the top cell is fed from cell 0 so a full
    // rotation restores the table.
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            yrst_pkg::rec_t left_rec;
            logic           left_gt;
            logic           occ;
            logic           tail;

            assign occ  = (FILL_W'(gi) < fill_reg);
            assign tail = (FILL_W'(gi) == fill_reg);

            if (gi == 0)
            begin : g_first
                assign left_rec = '0;
                assign left_gt  = 1'b0;
            end
            else
            begin : g_rest
                assign left_rec = cell_rec[gi-1];
                assign left_gt  = cell_gt[gi-1];
            end

            yrst_cell u_cell
            (
                .clk       (clk),
                .ctrl      (ctrl),
                .occ       (occ),
                .tail      (tail),
                .left_rec  (left_rec),
                .left_gt   (left_gt),
                .right_rec (cell_rec[(gi + 1) % CAPACITY]),
                .rec       (cell_rec[gi]),
                .gt        (cell_gt[gi]),
                .match     (cell_match[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        step_next      = step_reg;
        mvec_next      = mvec_reg;
        list_all_next  = list_all_reg;
        req_next       = req_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        out_rec_next   = out_rec_reg;
        last_next      = last_reg;

        ctrl.cmd      = yrst_pkg::CMD_HOLD;
        ctrl.list_all = list_all_reg;
        ctrl.new_rec  = req_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next.year    = year;
                    req_next.letters = plate_letters;
                    req_next.digits  = plate_digits;
                    list_all_next    = (req_type == yrst_pkg::REQ_LIST_ALL);
                    if (req_type == yrst_pkg::REQ_INSERT)
                    begin
                        state_next = S_INSERT;
                    end
                    else if (req_type == yrst_pkg::REQ_LIST_ALL ||
                             req_type == yrst_pkg::REQ_LIST_YR)
                    begin
                        state_next = S_LSTART;
                    end
                end
            end
            S_INSERT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_rec_next   = '0;
                    last_next      = 1'b1;
                    if (table_full)
                    begin
                        status_next = yrst_pkg::ST_FULL;
                    end
                    else
                    begin
                        status_next = yrst_pkg::ST_INSERTED;
                        ctrl.cmd    = yrst_pkg::CMD_INSERT;
                        fill_next   = fill_reg + 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            S_LSTART:
            begin
                if (cell_match == '0)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = yrst_pkg::ST_NONE;
                        out_rec_next   = '0;
                        last_next      = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    mvec_next  = cell_match;
                    step_next  = '0;
                    state_next = S_LIST;
                end
            end
            S_LIST:
            begin
                // Cell 0 holds the record whose turn it is; pause only when
                // it must be emitted and the output register is busy.
                if (!mvec_reg[0] || out_free)
                begin
                    ctrl.cmd = yrst_pkg::CMD_ROTATE;
                    if (mvec_reg[0])
                    begin
                        out_valid_next = 1'b1;
                        status_next    = yrst_pkg::ST_RECORD;
                        out_rec_next   = cell_rec[0];
                        last_next      = ((mvec_reg >> 1) == '0);
                    end
                    mvec_next = mvec_reg >> 1;
                    step_next = step_reg + 1'b1;
                    if (step_reg == STEP_W'(CAPACITY - 1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            step_reg      <= '0;
            mvec_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            step_reg      <= step_next;
            mvec_reg      <= mvec_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        list_all_reg <= list_all_next;
        req_reg      <= req_next;
        status_reg   <= status_next;
        out_rec_reg  <= out_rec_next;
        last_reg     <= last_next;
    end

`ifndef SYNTHESIS
    // The record count never passes the table size.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(CAPACITY))
        else $error("record count exceeds capacity");

    // The record count only ever grows by one, on a successful insert.
    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(fill_reg) |-> (fill_reg == $past(fill_reg) + 1'b1) &&
                               ($past(state_reg) == S_INSERT))
        else $error("record count changed unexpectedly");

    // Every result other than an emitted record closes its request.
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == yrst_pkg::ST_RECORD) || last)
        else $error("single-beat result without last");

    // A listing never leaves the rotation with records still to emit.
    a_list_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LIST) && (state_next == S_IDLE) |-> (mvec_next == '0))
        else $error("listing finished with records pending");
`endif

endmodule

// File: bench/year_sorted_record_table_test.sv
// Self-checking testbench for year_sorted_record_table: a scoreboard class predicts the
// result beats of each accepted request, and tasks and processes drive both channels.
// Depends on yrst_pkg and the year_sorted_record_table RTL.
`timescale 1ns / 1ps

module year_sorted_record_table_test;

    localparam int          TB_CAPACITY = yrst_pkg::CAPACITY_DEF;
    localparam int          YEAR_W      = yrst_pkg::YEAR_W;
    localparam int          LETTERS_W   = yrst_pkg::LETTERS_W;
    localparam int          DIGITS_W    = yrst_pkg::DIGITS_W;
    localparam logic [1:0]  REQ_UNUSED  = 2'd3;
    localparam int          HOLD_CYCLES = 300;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          PHASE_ITEMS = 16;

    // One result beat as the output channel presents it.
    typedef struct packed {
        logic [1:0]           status;
        logic [YEAR_W-1:0]    year;
        logic [LETTERS_W-1:0] letters;
        logic [DIGITS_W-1:0]  digits;
        logic                 last;
    } table_beat_t;

    // The scoreboard keeps its own copy of the sorted table and a queue of the
    // beats that the requests accepted so far must still produce.
    class record_table_scoreboard;
        logic [YEAR_W-1:0]    years   [TB_CAPACITY];
        logic [LETTERS_W-1:0] letters [TB_CAPACITY];
        logic [DIGITS_W-1:0]  digits  [TB_CAPACITY];
        int unsigned          stored;
        table_beat_t          beats_due [$];
        int mismatches;
        int requests_seen;
        int beats_checked;
        int inserts_taken;
        int inserts_refused;
        int listings;
        int record_beats;
        int none_beats;

        function table_beat_t make_beat(logic [1:0] st, logic [YEAR_W-1:0] yr,
                                        logic [LETTERS_W-1:0] lt,
                                        logic [DIGITS_W-1:0] dg, logic fin);
            table_beat_t b;
            b.status  = st;
            b.year    = yr;
            b.letters = lt;
            b.digits  = dg;
            b.last    = fin;
            return b;
        endfunction

        // Called for every request beat the block accepts.
        function void note_request(logic [1:0] req_code, logic [YEAR_W-1:0] yr,
                                   logic [LETTERS_W-1:0] lt, logic [DIGITS_W-1:0] dg);
            int          pos;
            int          j;
            int          found;
            table_beat_t tail;
            found = 0;
            requests_seen++;
            case (req_code)
                yrst_pkg::REQ_INSERT:
                begin
                    if (stored >= TB_CAPACITY)
                    begin
                        inserts_refused++;
                        beats_due.push_back(make_beat(yrst_pkg::ST_FULL, '0, '0, '0, 1'b1));
                    end
                    else
                    begin
                        // The new record goes after every record of equal or lower year.
                        pos = stored;
                        while (pos > 0 && years[pos-1] > yr)
                            pos--;
                        for (j = stored; j > pos; j--)
                        begin
                            years[j]   = years[j-1];
                            letters[j] = letters[j-1];
                            digits[j]  = digits[j-1];
                        end
                        years[pos]   = yr;
                        letters[pos] = lt;
                        digits[pos]  = dg;
                        stored++;
                        inserts_taken++;
                        beats_due.push_back(make_beat(yrst_pkg::ST_INSERTED, '0, '0, '0,
                                                      1'b1));
                    end
                end
                yrst_pkg::REQ_LIST_ALL, yrst_pkg::REQ_LIST_YR:
                begin
                    listings++;
                    for (j = 0; j < stored; j++)
                    begin
                        if (req_code == yrst_pkg::REQ_LIST_YR && years[j] != yr)
                            continue;
                        beats_due.push_back(make_beat(yrst_pkg::ST_RECORD, years[j],
                                                      letters[j], digits[j], 1'b0));
                        found++;
                        record_beats++;
                    end
                    if (found == 0)
                    begin
                        none_beats++;
                        beats_due.push_back(make_beat(yrst_pkg::ST_NONE, '0, '0, '0, 1'b1));
                    end
                    else
                    begin
                        tail = beats_due.pop_back();
                        tail.last = 1'b1;
                        beats_due.push_back(tail);
                    end
                end
                default:
                begin
                    // Unused request code: dropped without a result.
                end
            endcase
        endfunction

        task report_mismatch(input string msg);
            mismatches++;
            if (mismatches <= 200)
                $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask

        // Called for every result beat the testbench accepts.
        task check_beat(input table_beat_t got);
            table_beat_t want;
            string       diffs;
            beats_checked++;
            if (beats_due.size() == 0)
            begin
                report_mismatch($sformatf("beat with nothing pending: status %0d year %0d last %0b",
                                          got.status, got.year, got.last));
                return;
            end
            want  = beats_due.pop_front();
            diffs = "";
            if (got.status !== want.status)
                diffs = {diffs, $sformatf(" status %0d/%0d", got.status, want.status)};
            if (got.year !== want.year)
                diffs = {diffs, $sformatf(" year %0d/%0d", got.year, want.year)};
            if (got.letters !== want.letters)
                diffs = {diffs, $sformatf(" letters %h/%h", got.letters, want.letters)};
            if (got.digits !== want.digits)
                diffs = {diffs, $sformatf(" digits %h/%h", got.digits, want.digits)};
            if (got.last !== want.last)
                diffs = {diffs, $sformatf(" last %b/%b", got.last, want.last)};
            if (diffs != "")
                report_mismatch({"result beat differs (got/expected):", diffs});
        endtask

        function int pending();
            return beats_due.size();
        endfunction

        // A year that is present in the table, if any, so that a year query finds something.
        function logic [YEAR_W-1:0] stored_year();
            if (stored == 0)
                return YEAR_W'($urandom);
            return years[$urandom_range(stored - 1)];
        endfunction
    endclass

    // Clock, reset and the block's ports. Every input starts at a known value.
    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 in_valid      = 1'b0;
    logic                 in_stall;
    logic [1:0]           req_type      = yrst_pkg::REQ_INSERT;
    logic [YEAR_W-1:0]    year          = '0;
    logic [LETTERS_W-1:0] plate_letters = '0;
    logic [DIGITS_W-1:0]  plate_digits  = '0;
    logic                 out_valid;
    logic                 out_stall     = 1'b0;
    logic [1:0]           status;
    logic [YEAR_W-1:0]    rec_year;
    logic [LETTERS_W-1:0] rec_letters;
    logic [DIGITS_W-1:0]  rec_digits;
    logic                 last;

    // Traffic shaping: percentages are per cycle; the hold-off is a long
    // receiver stall run by its own process.
    int   sender_idle_pct    = 0;
    int   receiver_stall_pct = 0;
    logic hold_wanted        = 1'b0;
    logic hold_active        = 1'b0;
    int   cycle_count;

    record_table_scoreboard board;

    year_sorted_record_table #(.CAPACITY(TB_CAPACITY)) dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .year          (year),
        .plate_letters (plate_letters),
        .plate_digits  (plate_digits),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .rec_year      (rec_year),
        .rec_letters   (rec_letters),
        .rec_digits    (rec_digits),
        .last          (last)
    );

    always #6 clk = ~clk;

    // The receiver stalls at random, and solidly while a hold-off runs. Both
    // monitors below read the values that stood just before the edge, which
    // is exactly what the block sees when it decides whether a beat moves.
    always @(posedge clk)
        out_stall <= hold_active || ($urandom_range(99) < receiver_stall_pct);

    always @(posedge clk)
        if (rst_n && in_valid && !in_stall)
            board.note_request(req_type, year, plate_letters, plate_digits);

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            board.check_beat({status, rec_year, rec_letters, rec_digits, last});

    // The hold-off keeps out_stall high long enough that the block's single
    // output register fills and in_stall rises while the sender keeps offering
    // requests.
    initial
    begin
        forever
        begin
            wait (hold_wanted);
            @(posedge clk);
            hold_active <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_active <= 1'b0;
            hold_wanted = 1'b0;
        end
    end

    // Watchdog: a run that is still going well past its slowest correct length
    // has lost a beat somewhere.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Watchdog expired with %0d result beats outstanding", board.pending());
        $display("year_sorted_record_table verification failed");
        $finish;
    end

    // Offers one request beat and returns at the edge that accepts it. Valid
    // stays high on return, so a follow-on beat without a gap needs only new
    // payload; a gap lowers valid first, and never in the step that raises it.
    task automatic send_request(input logic [1:0]           req_code,
                                input logic [YEAR_W-1:0]    yr,
                                input logic [LETTERS_W-1:0] lt,
                                input logic [DIGITS_W-1:0]  dg);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct)
                @(posedge clk);
        end
        in_valid      <= 1'b1;
        req_type      <= req_code;
        year          <= yr;
        plate_letters <= lt;
        plate_digits  <= dg;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Random request. The table fills early and is never emptied, so the mix
    // leans towards year queries that hit stored years; counted is low for the
    // unused code, which the block simply drops.
    task automatic send_random_request(output bit counted);
        int                   pick;
        logic [1:0]           code;
        logic [YEAR_W-1:0]    yr;
        pick    = $urandom_range(99);
        counted = 1'b1;
        yr      = YEAR_W'($urandom);
        if (pick < 30)
        begin
            code = yrst_pkg::REQ_INSERT;
            case ($urandom_range(3))
                0: yr = YEAR_W'($urandom_range(1990, 1994));
                1: yr = '0;
                2: yr = '1;
                default: ;
            endcase
        end
        else if (pick < 50)
            code = yrst_pkg::REQ_LIST_ALL;
        else if (pick < 90)
        begin
            code = yrst_pkg::REQ_LIST_YR;
            if ($urandom_range(3) != 0)
                yr = board.stored_year();
        end
        else
        begin
            code    = REQ_UNUSED;
            counted = 1'b0;
        end
        send_request(code, yr, LETTERS_W'($urandom), DIGITS_W'($urandom));
    endtask

    initial
    begin
        int sender_plan   [4];
        int receiver_plan [4];
        int done;
        bit counted;
        sender_plan   = '{0, 73, 0, 25};
        receiver_plan = '{0, 0, 73, 25};
        board = new();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty listings, the unused code, extreme field values,
        // equal years in arrival order, a full table and the various queries.
        sender_idle_pct    = 25;
        receiver_stall_pct = 25;
        send_request(yrst_pkg::REQ_LIST_ALL, 12'd0,    24'h000000, 32'h00000000);
        send_request(yrst_pkg::REQ_LIST_YR,  12'd2000, 24'h000000, 32'h00000000);
        send_request(REQ_UNUSED,             12'd2000, 24'h414243, 32'h31323334);
        send_request(yrst_pkg::REQ_INSERT,   12'd2000, 24'h414243, 32'h31323334);
        send_request(yrst_pkg::REQ_INSERT,   12'd0,    24'h000000, 32'h00000000);
        send_request(yrst_pkg::REQ_INSERT,   12'd4095, 24'hFFFFFF, 32'hFFFFFFFF);
        send_request(yrst_pkg::REQ_LIST_ALL, 12'd4095, 24'hFFFFFF, 32'hFFFFFFFF);
        send_request(yrst_pkg::REQ_INSERT,   12'd2000, 24'h5A5A5A, 32'hA5A5A5A5);
        send_request(yrst_pkg::REQ_INSERT,   12'd1999, 24'hA5A5A5, 32'h5A5A5A5A);
        send_request(yrst_pkg::REQ_INSERT,   12'd2000, 24'h123456, 32'h89ABCDEF);
        send_request(yrst_pkg::REQ_INSERT,   12'd4095, 24'h000001, 32'h80000000);
        send_request(yrst_pkg::REQ_INSERT,   12'd0,    24'h800000, 32'h00000001);
        send_request(yrst_pkg::REQ_INSERT,   12'd2001, 24'h4C4D4E, 32'h39383736);
        send_request(yrst_pkg::REQ_INSERT,   12'd1500, 24'h58595A, 32'h30303030);
        send_request(yrst_pkg::REQ_INSERT,   12'd3000, 24'hFFFFFF, 32'hFFFFFFFF);
        send_request(yrst_pkg::REQ_LIST_ALL, 12'd0,    24'h000000, 32'h00000000);
        send_request(yrst_pkg::REQ_LIST_YR,  12'd2000, 24'h000000, 32'h00000000);
        send_request(yrst_pkg::REQ_LIST_YR,  12'd4095, 24'h000000, 32'h00000000);
        send_request(yrst_pkg::REQ_LIST_YR,  12'd0,    24'h000000, 32'h00000000);
        send_request(yrst_pkg::REQ_LIST_YR,  12'd1234, 24'h000000, 32'h00000000);

        // Random part, one batch per traffic pattern.
        for (int phase = 0; phase < 4; phase++)
        begin
            sender_idle_pct    = sender_plan[phase];
            receiver_stall_pct = receiver_plan[phase];
            done = 0;
            while (done < PHASE_ITEMS)
            begin
                send_random_request(counted);
                if (counted)
                    done++;
            end
        end

        // Back-pressure batch: the sender never rests while the receiver holds off.
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_wanted        = 1'b1;
        done = 0;
        while (done < PHASE_ITEMS)
        begin
            send_random_request(counted);
            if (counted)
                done++;
        end
        in_valid <= 1'b0;

        // Drain, then wait on a while longer for any stray beat.
        while (board.pending() != 0)
            @(posedge clk);
        repeat (4 * TB_CAPACITY) @(posedge clk);

        $display("Covered %0d requests: %0d inserts stored, %0d refused as full, %0d listings",
                 board.requests_seen, board.inserts_taken, board.inserts_refused,
                 board.listings);
        $display("Checked %0d result beats (%0d records, %0d none-found), %0d mismatches",
                 board.beats_checked, board.record_beats, board.none_beats,
                 board.mismatches);
        if (board.mismatches == 0)
            $display("year_sorted_record_table verification clean");
        else
            $display("year_sorted_record_table verification failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/yrst_pkg.sv
rtl/yrst_cell.sv
rtl/year_sorted_record_table.sv
bench/year_sorted_record_table_test.sv
